### rtl/buzzer_beep_siren_sequencer_core_assert.svh
// Assertion macros used by the sequencer core.
`ifndef BUZZER_BEEP_SIREN_SEQUENCER_CORE_ASSERT_SVH
`define BUZZER_BEEP_SIREN_SEQUENCER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBSS_ASSERT_SAME(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BBSS_ASSERT_NEXT(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("sequencer assertion failed");

`endif

### rtl/bbss_pkg.sv
`default_nettype none
package bbss_pkg;

	localparam int unsigned MIN_INTERVAL_MS = 5;
	localparam int unsigned SWEEP_STEP_HZ   = 10;

	localparam int unsigned DIV_W       = 32;
	localparam int unsigned DIV_SHORT_N = 8;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_BEEP  = 2'd1;
	localparam logic [1:0] FUNC_SIREN = 2'd2;
	localparam logic [1:0] FUNC_STOP  = 2'd3;

	localparam logic [2:0] REG_ON_DURATION    = 3'd0;
	localparam logic [2:0] REG_OFF_DURATION   = 3'd1;
	localparam logic [2:0] REG_PAUSE_DURATION = 3'd2;
	localparam logic [2:0] REG_BEEPS_PER_SEQ  = 3'd3;
	localparam logic [2:0] REG_SEQUENCE_COUNT = 3'd4;
	localparam logic [2:0] REG_SIREN_DELAY    = 3'd5;
	localparam logic [2:0] REG_OUTPUT_ENABLED = 3'd6;

	typedef struct packed {
		logic             start;
		logic             short_mode;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

### rtl/bbss_div.sv
`default_nettype none
module bbss_div (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  bbss_pkg::div_req_t req,
	output bbss_pkg::div_rsp_t rsp
);
	import bbss_pkg::*;

	// In short mode the quotient is known to fit in the low bits, so the
	// upper dividend bits are preloaded as the partial remainder.
	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W-1:0] quo_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0] rem_sh;
	logic           ge;
	logic [DIV_W:0] rem_nx;

	assign rem_sh = {rem_q[DIV_W-1:0], dvd_q[DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				if (req.short_mode) begin
					cnt_q <= 6'(DIV_SHORT_N);
				end else begin
					cnt_q <= 6'(DIV_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dsr_q <= req.divisor;
			quo_q <= '0;
			if (req.short_mode) begin
				rem_q <= {{(DIV_SHORT_N + 1){1'b0}}, req.dividend[DIV_W-1:DIV_SHORT_N]};
				dvd_q <= {req.dividend[DIV_SHORT_N-1:0], {(DIV_W - DIV_SHORT_N){1'b0}}};
			end else begin
				rem_q <= '0;
				dvd_q <= req.dividend;
			end
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q[DIV_W-1:0];

endmodule
`default_nettype wire

### rtl/buzzer_beep_siren_sequencer_core.sv
// Buzzer beep and siren sequencer.
// Command items arrive on the s_axis channel, one per timestamp, with the
// command code in tuser. Each accepted item yields exactly one result item
// on the m_axis channel giving the tone state after the command's update.
// Registers are written on the cfg channel, which is always ready, and
// must only be written while no item is in flight.
// A skipped update passes from acceptance through ST_CMD and ST_CHECK to
// ST_DONE, a siren update also through ST_SIREN, and a beep update with an
// empty sequence through ST_SETUP, ST_MUL, ST_SEQ and ST_DIVS. Any other beep
// update runs a shared serial restoring divider: 32 steps for the position
// within the pattern and, when that position falls in a beep, another 8 steps
// for the position within it. That divider sets the throughput; the block
// takes one item at a time, s_axis_tready is low while an item is in work
// and rises as its result is offered.
// The result is held in an output register; a new item is accepted while
// it waits, but the next result stalls until m_axis_tready takes it.
// Reset clears the control state and loads the register defaults; no
// result is pending afterwards.
`default_nettype none
`include "buzzer_beep_siren_sequencer_core_assert.svh"
module buzzer_beep_siren_sequencer_core (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_axis_tvalid,
	output logic              s_axis_tready,
	// current_time[31:0], frequency[47:32], end_frequency[63:48],
	// rise_and_fall[64], zero fill above.
	input  wire  logic [71:0] s_axis_tdata,
	// func[1:0].
	input  wire  logic [1:0]  s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire  logic        m_axis_tready,
	// buzzer_on[0], tone_frequency[16:1], tone_reprogram[17], finished[18],
	// busy_res[19], zero fill above.
	output logic [23:0]       m_axis_tdata,
	input  wire  logic        cfg_valid,
	output logic              cfg_ready,
	input  wire  logic [2:0]  cfg_index,
	input  wire  logic [15:0] cfg_data
);
	import bbss_pkg::*;

	localparam logic [31:0] MIN_IVL  = 32'(MIN_INTERVAL_MS);
	localparam logic [15:0] MIN_DUR  = 16'(MIN_INTERVAL_MS);
	localparam logic [16:0] STEP_HZ  = 17'(SWEEP_STEP_HZ);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CMD   = 4'd1;
	localparam logic [3:0] ST_CHECK = 4'd2;
	localparam logic [3:0] ST_SIREN = 4'd3;
	localparam logic [3:0] ST_SETUP = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_SEQ   = 4'd6;
	localparam logic [3:0] ST_DIVS  = 4'd7;
	localparam logic [3:0] ST_DIV1  = 4'd8;
	localparam logic [3:0] ST_DIV2  = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	logic [3:0] state_q;

	logic [15:0] on_dur_q;
	logic [15:0] off_dur_q;
	logic [15:0] pause_dur_q;
	logic [7:0]  beeps_q;
	logic [15:0] seq_count_q;
	logic [15:0] siren_delay_q;
	logic        out_en_q;

	logic [1:0]  func_q;
	logic [31:0] now_q;
	logic [15:0] freq_q;
	logic [15:0] endf_q;
	logic        raf_q;

	logic [31:0] start_stamp_q;
	logic [31:0] last_acc_q;
	logic [31:0] last_step_q;
	logic        siren_mode_q;
	logic        sounding_q;
	logic        silenced_q;
	logic [15:0] play_freq_q;
	logic [15:0] sweep_low_q;
	logic [15:0] sweep_high_q;
	logic        sweep_rising_q;
	logic        sweep_bounce_q;
	logic        reprog_q;
	logic        finished_q;

	logic [15:0] on_c_q;
	logic [15:0] off_c_q;
	logic [15:0] pause_c_q;
	logic [16:0] blink_q;
	logic [24:0] active_q;
	logic [25:0] seq_q;
	logic [31:0] elapsed_q;

	logic        m_valid_q;
	logic [23:0] m_data_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [16:0] rise_sum;
	logic [15:0] rise_freq;
	logic [15:0] fall_freq;
	logic        pos_in_beep;
	logic        seq_over;

	function automatic logic [15:0] clamp_dur(input logic [15:0] d);
		logic [15:0] r;
		if (d == 16'd0) begin
			r = 16'd0;
		end else if (d < MIN_DUR) begin
			r = MIN_DUR;
		end else begin
			r = d;
		end
		return r;
	endfunction

	bbss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign rise_sum  = {1'b0, play_freq_q} + STEP_HZ;
	assign rise_freq = rise_sum[16] ? 16'hFFFF : rise_sum[15:0];
	assign fall_freq = ({1'b0, play_freq_q} >= STEP_HZ) ?
		16'({1'b0, play_freq_q} - STEP_HZ) : 16'd0;

	assign seq_over = (seq_count_q != 16'd0) &&
		(div_rsp.quotient >= {16'd0, seq_count_q});
	assign pos_in_beep = (div_rsp.remainder < {7'd0, active_q}) && (blink_q != 17'd0);

	always_comb begin
		div_req = '0;
		if (state_q == ST_DIVS) begin
			div_req.start    = seq_q != 26'd0;
			div_req.dividend = elapsed_q;
			div_req.divisor  = {6'd0, seq_q};
		end else if (state_q == ST_DIV1) begin
			div_req.start      = div_rsp.done && !seq_over && pos_in_beep;
			div_req.short_mode = 1'b1;
			div_req.dividend   = div_rsp.remainder;
			div_req.divisor    = {15'd0, blink_q};
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_dur_q      <= 16'd100;
			off_dur_q     <= 16'd100;
			pause_dur_q   <= 16'd200;
			beeps_q       <= 8'd1;
			seq_count_q   <= 16'd1;
			siren_delay_q <= 16'd10;
			out_en_q      <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ON_DURATION:    on_dur_q      <= cfg_data;
				REG_OFF_DURATION:   off_dur_q     <= cfg_data;
				REG_PAUSE_DURATION: pause_dur_q   <= cfg_data;
				REG_BEEPS_PER_SEQ:  beeps_q       <= cfg_data[7:0];
				REG_SEQUENCE_COUNT: seq_count_q   <= cfg_data;
				REG_SIREN_DELAY:    siren_delay_q <= cfg_data;
				REG_OUTPUT_ENABLED: out_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && state_q == ST_IDLE) begin
			func_q <= s_axis_tuser;
			now_q  <= s_axis_tdata[31:0];
			freq_q <= s_axis_tdata[47:32];
			endf_q <= s_axis_tdata[63:48];
			raf_q  <= s_axis_tdata[64];
		end
		if (state_q == ST_SETUP) begin
			on_c_q    <= clamp_dur(on_dur_q);
			off_c_q   <= clamp_dur(off_dur_q);
			pause_c_q <= clamp_dur(pause_dur_q);
			blink_q   <= {1'b0, clamp_dur(on_dur_q)} + {1'b0, clamp_dur(off_dur_q)};
		end
		if (state_q == ST_MUL) begin
			active_q  <= {8'd0, blink_q} * {17'd0, beeps_q};
			elapsed_q <= now_q - start_stamp_q;
		end
		if (state_q == ST_SEQ) begin
			if (beeps_q == 8'd0) begin
				seq_q <= {10'd0, pause_c_q};
			end else begin
				seq_q <= {1'b0, active_q} + {10'd0, pause_c_q} - {10'd0, off_c_q};
			end
		end
		if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
			m_data_q <= {4'd0, (start_stamp_q != 32'd0), finished_q, reprog_q,
				play_freq_q, sounding_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			m_valid_q      <= 1'b0;
			start_stamp_q  <= '0;
			last_acc_q     <= '0;
			last_step_q    <= '0;
			siren_mode_q   <= 1'b0;
			sounding_q     <= 1'b0;
			silenced_q     <= 1'b0;
			play_freq_q    <= '0;
			sweep_low_q    <= '0;
			sweep_high_q   <= '0;
			sweep_rising_q <= 1'b1;
			sweep_bounce_q <= 1'b0;
			reprog_q       <= 1'b0;
			finished_q     <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						reprog_q   <= 1'b0;
						finished_q <= 1'b0;
						state_q    <= ST_CMD;
					end
				end
				ST_CMD: begin
					if (func_q == FUNC_BEEP || func_q == FUNC_SIREN) begin
						siren_mode_q <= func_q == FUNC_SIREN;
						play_freq_q  <= freq_q;
						if (func_q == FUNC_SIREN) begin
							sweep_bounce_q <= raf_q;
							if (endf_q > freq_q) begin
								sweep_low_q    <= freq_q;
								sweep_high_q   <= endf_q;
								sweep_rising_q <= 1'b1;
							end else begin
								sweep_low_q    <= endf_q;
								sweep_high_q   <= freq_q;
								sweep_rising_q <= 1'b0;
							end
						end
						start_stamp_q <= (now_q != 32'd0) ? now_q : 32'd1;
						last_acc_q    <= '0;
						sounding_q    <= 1'b0;
						silenced_q    <= 1'b0;
					end else if (func_q == FUNC_STOP) begin
						start_stamp_q <= '0;
						sounding_q    <= 1'b0;
						silenced_q    <= 1'b0;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (now_q - last_acc_q < MIN_IVL) begin
						state_q <= ST_DONE;
					end else begin
						last_acc_q <= now_q;
						if (start_stamp_q == 32'd0 || !out_en_q) begin
							state_q <= ST_DONE;
						end else if (siren_mode_q) begin
							state_q <= ST_SIREN;
						end else begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SIREN: begin
					if (!sounding_q) begin
						sounding_q  <= 1'b1;
						reprog_q    <= 1'b1;
						last_step_q <= now_q;
					end else if (now_q - last_step_q >= {16'd0, siren_delay_q}) begin
						if (sweep_rising_q) begin
							if (rise_freq >= sweep_high_q) begin
								if (sweep_bounce_q) begin
									play_freq_q    <= rise_freq;
									sweep_rising_q <= 1'b0;
								end else begin
									play_freq_q <= sweep_low_q;
								end
							end else begin
								play_freq_q <= rise_freq;
							end
						end else begin
							if (fall_freq <= sweep_low_q) begin
								if (sweep_bounce_q) begin
									play_freq_q    <= fall_freq;
									sweep_rising_q <= 1'b1;
								end else begin
									play_freq_q <= sweep_high_q;
								end
							end else begin
								play_freq_q <= fall_freq;
							end
						end
						reprog_q    <= 1'b1;
						last_step_q <= now_q;
					end
					state_q <= ST_DONE;
				end
				ST_SETUP: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_SEQ;
				ST_SEQ:   state_q <= ST_DIVS;
				ST_DIVS: begin
					if (seq_q == 26'd0) begin
						start_stamp_q <= '0;
						sounding_q    <= 1'b0;
						silenced_q    <= 1'b0;
						finished_q    <= 1'b1;
						state_q       <= ST_DONE;
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						if (seq_over) begin
							start_stamp_q <= '0;
							sounding_q    <= 1'b0;
							silenced_q    <= 1'b0;
							finished_q    <= 1'b1;
							state_q       <= ST_DONE;
						end else if (pos_in_beep) begin
							state_q <= ST_DIV2;
						end else begin
							if (!silenced_q) begin
								silenced_q <= 1'b1;
								sounding_q <= 1'b0;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						if (div_rsp.remainder < {16'd0, on_c_q}) begin
							if (!sounding_q) begin
								reprog_q   <= 1'b1;
								sounding_q <= 1'b1;
								silenced_q <= 1'b0;
							end
						end else if (!silenced_q) begin
							silenced_q <= 1'b1;
							sounding_q <= 1'b0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BBSS_ASSERT_SAME(a_finish_idle, clk, arst_n, m_valid_q && m_data_q[18], !m_data_q[19] && !m_data_q[0])
	`BBSS_ASSERT_SAME(a_reprog_sounds, clk, arst_n, m_valid_q && m_data_q[17], m_data_q[0])
	`BBSS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !div_rsp.done)

endmodule
`default_nettype wire
